@@ sv/mip_chain_box_downsampler_assert.svh @@
// assertion macros for the mip chain downsampler
`ifndef MIP_CHAIN_BOX_DOWNSAMPLER_ASSERT_SVH
`define MIP_CHAIN_BOX_DOWNSAMPLER_ASSERT_SVH
`define MCBD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MCBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ sv/mcbd_pkg.sv @@
// types and constants for the mip chain downsampler
package mcbd_pkg;
  localparam int unsigned Channels = 4;
  localparam logic [0:0] RegLog2Width = 1'b0;
  localparam logic [0:0] RegLog2Height = 1'b1;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [3:0] mip_level;
    logic [9:0] pos_x;
    logic [9:0] pos_y;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic last_of_run;
    logic chain_done;
  } pix_out_t;

  typedef logic [31:0] rgba_t;
  typedef logic [35:0] rgba9_t;
endpackage

@@ sv/mcbd_level_cell.sv @@
// one cell of the chain: position and horizontal pairing for one mip level
module mcbd_level_cell #(
  parameter int unsigned PW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          restart,
  input  logic          step,
  input  logic [3:0]    w,
  input  logic [3:0]    h,
  input  mcbd_pkg::rgba_t px,
  output logic [PW-1:0] x,
  output logic [PW-1:0] y,
  output logic          pair_ready,
  output mcbd_pkg::rgba9_t hs
);
  mcbd_pkg::rgba_t hold;
  logic [PW-1:0] x_next;
  logic [PW-1:0] y_next;
  logic [PW:0] x_inc;
  logic [PW:0] y_inc;
  logic [PW:0] wlim;
  logic [PW:0] hlim;

  assign wlim = (PW+1)'(1) << w;
  assign hlim = (PW+1)'(1) << h;
  assign x_inc = {1'b0, x} + (PW+1)'(1);
  assign y_inc = {1'b0, y} + (PW+1)'(1);
  assign pair_ready = (w == 4'd0) || x[0];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (w == 4'd0) hs[c*9 +: 9] = {px[c*8 +: 8], 1'b0};
      else hs[c*9 +: 9] = {1'b0, hold[c*8 +: 8]} + {1'b0, px[c*8 +: 8]};
    end
    x_next = x_inc[PW-1:0];
    y_next = y;
    if (x_inc >= wlim) begin
      x_next = '0;
      y_next = y_inc[PW-1:0];
      if (y_inc >= hlim) y_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      x <= '0;
      y <= '0;
    end else if (step) begin
      x <= x_next;
      y <= y_next;
    end
    if (step && w != 4'd0 && !x[0]) hold <= px;
  end
endmodule

@@ sv/mip_chain_box_downsampler.sv @@
// Mip chain builder: accepts RGBA8 base pixels in raster order and emits every
// pixel of levels 1..n as its 2x2 block completes. Each input walks a chain of
// per-level cells with a READ and a CALC state per level: the row-sum memory is
// read in READ and used and written in CALC. An input costs an accept in IDLE
// plus a READ and a CALC for each level it visits, which is every level that
// yields a result and the level after it, if there is one. A result sits in the
// output register until taken, the next level waits in its READ state while it
// is stalled, and the next input is held off until the last result is taken.
// Configuration writes have priority over input beats. The row-sum memory is
// not cleared after reset.
module mip_chain_box_downsampler #(
  parameter int unsigned MAX_LOG2 = 11
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mcbd_pkg::pix_in_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mcbd_pkg::pix_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [3:0]        cfg_data
);
  localparam int unsigned LW = $clog2(MAX_LOG2 + 1);
  localparam int unsigned PW = MAX_LOG2;
  localparam int unsigned DEPTH = 1 << MAX_LOG2;

  typedef enum logic [1:0] {IDLE, READ, CALC} state_t;
  state_t state;

  logic [3:0] log2_width, log2_height;
  logic [3:0] lw, lh, n;
  logic [LW-1:0] lvl;
  logic [PW-1:0] base;
  mcbd_pkg::rgba_t px;
  logic cfg_wr;
  logic [MAX_LOG2-1:0] step_vec;
  logic [PW-1:0] xs [MAX_LOG2];
  logic [PW-1:0] ys [MAX_LOG2];
  logic [MAX_LOG2-1:0] prs;
  logic [MAX_LOG2:0] brs;
  mcbd_pkg::rgba9_t hss [MAX_LOG2];
  logic [3:0] wv [MAX_LOG2];
  logic [3:0] hv [MAX_LOG2];

  logic [35:0] mem [DEPTH];
  logic [35:0] rd;
  logic [3:0] w_cur, h_cur;
  logic [PW-1:0] x_cur, y_cur, xo, yo, idx;
  mcbd_pkg::rgba9_t hs_cur;
  logic pr_cur, block_ready, next_ready, last_run;
  mcbd_pkg::rgba_t avg;
  logic [9:0] t [4];

  assign lw = (log2_width > 4'(MAX_LOG2)) ? 4'(MAX_LOG2) : log2_width;
  assign lh = (log2_height > 4'(MAX_LOG2)) ? 4'(MAX_LOG2) : log2_height;
  assign n = (lw > lh) ? lw : lh;
  assign cfg_ready = (state == IDLE) && !out_valid;
  assign cfg_wr = cfg_valid && cfg_ready;
  assign in_stall = !((state == IDLE) && !out_valid && !cfg_valid);
  assign brs[MAX_LOG2] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < MAX_LOG2; g++) begin : g_cell
      assign wv[g] = (lw > 4'(g)) ? lw - 4'(g) : 4'd0;
      assign hv[g] = (lh > 4'(g)) ? lh - 4'(g) : 4'd0;
      assign step_vec[g] = (state == CALC) && (lvl == LW'(g));
      assign brs[g] = prs[g] && ((hv[g] == 4'd0) || ys[g][0]);
      mcbd_level_cell #(.PW(PW)) u_cell (
        .clk(clk), .rst(rst), .restart(cfg_wr), .step(step_vec[g]),
        .w(wv[g]), .h(hv[g]), .px(px), .x(xs[g]), .y(ys[g]),
        .pair_ready(prs[g]), .hs(hss[g])
      );
    end
  endgenerate

  always_comb begin
    w_cur = wv[lvl];
    h_cur = hv[lvl];
    x_cur = xs[lvl];
    y_cur = ys[lvl];
    hs_cur = hss[lvl];
    pr_cur = prs[lvl];
    xo = (w_cur != 4'd0) ? (x_cur >> 1) : '0;
    yo = (h_cur != 4'd0) ? (y_cur >> 1) : '0;
    idx = base + xo;
    block_ready = brs[lvl];
    next_ready = brs[lvl + LW'(1)];
    last_run = (4'(lvl) + 4'd1 == n) || !next_ready;
    for (int c = 0; c < 4; c++) begin
      if (h_cur == 4'd0) t[c] = {hs_cur[c*9 +: 9], 1'b0};
      else t[c] = {1'b0, rd[c*9 +: 9]} + {1'b0, hs_cur[c*9 +: 9]};
      avg[c*8 +: 8] = t[c][9:2];
    end
  end

  always_ff @(posedge clk) begin
    rd <= mem[idx];
    if (state == CALC && pr_cur && h_cur != 4'd0 && !y_cur[0]) mem[idx] <= hs_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      out_valid <= 1'b0;
      log2_width <= '0;
      log2_height <= '0;
      lvl <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_wr) begin
        if (cfg_index == mcbd_pkg::RegLog2Width) log2_width <= cfg_data;
        else log2_height <= cfg_data;
      end
      case (state)
        IDLE: begin
          if (in_valid && !in_stall) begin
            px <= {in_data.alpha_in, in_data.blue_in, in_data.green_in, in_data.red_in};
            lvl <= '0;
            base <= '0;
            if (n != 4'd0) state <= READ;
          end
        end
        READ: begin
          if (!out_valid || !out_stall) state <= CALC;
        end
        CALC: begin
          if (block_ready) begin
            out_data.mip_level <= 4'(lvl) + 4'd1;
            out_data.pos_x <= 10'(xo);
            out_data.pos_y <= 10'(yo);
            out_data.red_out <= avg[7:0];
            out_data.green_out <= avg[15:8];
            out_data.blue_out <= avg[23:16];
            out_data.alpha_out <= avg[31:24];
            out_data.chain_done <= (4'(lvl) + 4'd1 == n);
            out_data.last_of_run <= last_run;
            out_valid <= 1'b1;
            px <= avg;
            base <= base + ((w_cur != 4'd0) ? (PW'(1) << (w_cur - 4'd1)) : PW'(1));
            if (4'(lvl) + 4'd1 == n) begin
              state <= IDLE;
            end else begin
              lvl <= lvl + LW'(1);
              state <= READ;
            end
          end else begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`include "mip_chain_box_downsampler_assert.svh"
  `MCBD_ASSERT_IMPL(a_cfg_idle, cfg_wr, state == IDLE)
  `MCBD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `MCBD_ASSERT_IMPL(a_no_accept_busy, state != IDLE, in_stall)
endmodule

@@ dv/mip_chain_box_downsampler_test.sv @@
// self-checking testbench for the mip chain box downsampler
`timescale 1ns / 100ps

module mip_chain_box_downsampler_test;
  localparam int unsigned MaxLog2 = 11;
  localparam int unsigned RowDepth = 1 << MaxLog2;
  localparam int unsigned DrainCycles = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  mcbd_pkg::pix_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mcbd_pkg::pix_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = mcbd_pkg::RegLog2Width;
  logic [3:0] cfg_data = '0;

  mcbd_pkg::pix_in_t pixel_feed[$];
  mcbd_pkg::pix_out_t mip_pixels_due[$];
  int unsigned mismatch_count = 0;
  bit steady_flow = 1'b0;

  logic [3:0] width_exp = '0;
  logic [3:0] height_exp = '0;
  logic [8:0] row_sum_mem[RowDepth][mcbd_pkg::Channels];
  logic [7:0] even_col_pixel[MaxLog2][mcbd_pkg::Channels];
  int unsigned col_at[MaxLog2];
  int unsigned row_at[MaxLog2];

  mip_chain_box_downsampler uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned clamp_exp(logic [3:0] v);
    return (v > MaxLog2) ? MaxLog2 : int'(v);
  endfunction

  function automatic void restart_frame();
    for (int i = 0; i < MaxLog2; i++) begin
      col_at[i] = 0;
      row_at[i] = 0;
    end
  endfunction

  function automatic void downsample_pixel(mcbd_pkg::pix_in_t p);
    int unsigned lw, lh, n, w, h, x, y, xo, yo, idx, base;
    logic [9:0] hs[mcbd_pkg::Channels];
    logic [10:0] total[mcbd_pkg::Channels];
    logic [7:0] px[mcbd_pkg::Channels];
    bit pair_ready, block_ready;
    mcbd_pkg::pix_out_t r;
    mcbd_pkg::pix_out_t run[$];
    lw = clamp_exp(width_exp);
    lh = clamp_exp(height_exp);
    n = (lw > lh) ? lw : lh;
    px[0] = p.red_in;
    px[1] = p.green_in;
    px[2] = p.blue_in;
    px[3] = p.alpha_in;
    base = 0;
    for (int lvl = 0; lvl < n; lvl++) begin
      w = (lw > lvl) ? lw - lvl : 0;
      h = (lh > lvl) ? lh - lvl : 0;
      x = col_at[lvl];
      y = row_at[lvl];
      xo = (w > 0) ? (x >> 1) : 0;
      yo = (h > 0) ? (y >> 1) : 0;
      idx = (base + xo) % RowDepth;
      pair_ready = 1'b1;
      block_ready = 1'b0;
      for (int c = 0; c < mcbd_pkg::Channels; c++) begin
        if (w == 0) begin
          hs[c] = 10'(px[c]) << 1;
        end else if (x[0] == 1'b0) begin
          even_col_pixel[lvl][c] = px[c];
          pair_ready = 1'b0;
        end else begin
          hs[c] = 10'(even_col_pixel[lvl][c]) + 10'(px[c]);
        end
      end
      if (pair_ready) begin
        for (int c = 0; c < mcbd_pkg::Channels; c++) begin
          if (h == 0) begin
            total[c] = 11'(hs[c]) << 1;
            block_ready = 1'b1;
          end else if (y[0] == 1'b0) begin
            row_sum_mem[idx][c] = hs[c][8:0];
          end else begin
            total[c] = 11'(row_sum_mem[idx][c]) + 11'(hs[c]);
            block_ready = 1'b1;
          end
        end
      end
      x++;
      if (x >= (1 << w)) begin
        x = 0;
        y++;
        if (y >= (1 << h)) y = 0;
      end
      col_at[lvl] = x;
      row_at[lvl] = y;
      if (!block_ready) break;
      for (int c = 0; c < mcbd_pkg::Channels; c++) px[c] = total[c][9:2];
      r.mip_level = 4'(lvl + 1);
      r.pos_x = 10'(xo);
      r.pos_y = 10'(yo);
      r.red_out = px[0];
      r.green_out = px[1];
      r.blue_out = px[2];
      r.alpha_out = px[3];
      r.last_of_run = 1'b0;
      r.chain_done = (lvl + 1 == n);
      run.push_back(r);
      base += (w > 0) ? (1 << (w - 1)) : 1;
    end
    if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
    foreach (run[i]) mip_pixels_due.push_back(run[i]);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) downsample_pixel(in_data);
      if (!in_valid || !in_stall) begin
        if (pixel_feed.size() > 0 && (steady_flow || $urandom_range(0, 99) >= 11)) begin
          in_data <= pixel_feed.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    mcbd_pkg::pix_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (mip_pixels_due.size() == 0) begin
        report_mismatch("unexpected beat level", out_data.mip_level, 0);
      end else begin
        want = mip_pixels_due.pop_front();
        if (out_data.mip_level !== want.mip_level)
          report_mismatch("mip_level", out_data.mip_level, want.mip_level);
        if (out_data.pos_x !== want.pos_x) report_mismatch("pos_x", out_data.pos_x, want.pos_x);
        if (out_data.pos_y !== want.pos_y) report_mismatch("pos_y", out_data.pos_y, want.pos_y);
        if (out_data.red_out !== want.red_out)
          report_mismatch("red_out", out_data.red_out, want.red_out);
        if (out_data.green_out !== want.green_out)
          report_mismatch("green_out", out_data.green_out, want.green_out);
        if (out_data.blue_out !== want.blue_out)
          report_mismatch("blue_out", out_data.blue_out, want.blue_out);
        if (out_data.alpha_out !== want.alpha_out)
          report_mismatch("alpha_out", out_data.alpha_out, want.alpha_out);
        if (out_data.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", out_data.last_of_run, want.last_of_run);
        if (out_data.chain_done !== want.chain_done)
          report_mismatch("chain_done", out_data.chain_done, want.chain_done);
      end
    end
    out_stall <= rst ? 1'b0 : (!steady_flow && $urandom_range(0, 99) < 11);
  end

  task automatic write_reg(logic [0:0] idx, logic [3:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    if (idx == mcbd_pkg::RegLog2Width) width_exp = value;
    else height_exp = value;
    restart_frame();
  endtask

  task automatic drain();
    do @(negedge clk); while (pixel_feed.size() > 0 || in_valid || mip_pixels_due.size() > 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic run_phase(logic [3:0] lw, logic [3:0] lh, int unsigned count,
                           int unsigned pattern);
    mcbd_pkg::pix_in_t p;
    drain();
    write_reg(mcbd_pkg::RegLog2Width, lw);
    write_reg(mcbd_pkg::RegLog2Height, lh);
    for (int i = 0; i < count; i++) begin
      case (pattern)
        0: p = '0;
        1: p = '1;
        2: p = (i % 2) ? '1 : '0;
        default: p = $urandom;
      endcase
      pixel_feed.push_back(p);
    end
  endtask

  initial begin
    int unsigned random_items;
    int unsigned lw, lh, frame;
    restart_frame();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // single pixel image, then extremes of the channels
    run_phase(4'd0, 4'd0, 3, 3);
    run_phase(4'd1, 4'd0, 4, 1);
    run_phase(4'd0, 4'd1, 2, 0);
    run_phase(4'd1, 4'd1, 8, 2);
    // restart in the middle of a frame
    run_phase(4'd2, 4'd1, 5, 3);
    run_phase(4'd13, 4'd12, 3, 3);

    random_items = 0;
    while (random_items < 40) begin
      lw = $urandom_range(0, 2);
      lh = $urandom_range(0, 2);
      frame = 1 << (lw + lh);
      frame = ($urandom_range(0, 3) == 0) ? $urandom_range(1, frame) : frame * $urandom_range(1, 2);
      run_phase(4'(lw), 4'(lh), frame, 3);
      random_items += frame;
    end

    // full chains of wider and taller images, one with no idling
    steady_flow = 1'b1;
    run_phase(4'd4, 4'd1, 32, 3);
    drain();
    steady_flow = 1'b0;
    run_phase(4'd0, 4'd4, 16, 3);
    drain();

    if (mismatch_count == 0) begin
      $display("mip_chain_box_downsampler_test: PASS");
    end else begin
      $display("mip_chain_box_downsampler_test: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("mip_chain_box_downsampler_test: FAIL");
    $finish;
  end
endmodule

@@ files.f @@
+incdir+sv
sv/mcbd_pkg.sv
sv/mcbd_level_cell.sv
sv/mip_chain_box_downsampler.sv
dv/mip_chain_box_downsampler_test.sv
